// File: design/bbs_pkg.sv
package bbs_pkg;

    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int CFG_SW_W   = 10;
    localparam int CFG_TW_W   = 11;
    localparam int TGT_REG_MAX = (1 << CFG_TW_W) - 1;

    localparam int DEF_MAX_SRC_W   = 512;
    localparam int DEF_MAX_SRC_H   = 512;
    localparam int DEF_MAX_DST_DIM = 1024;

    localparam logic [CFG_SW_W-1:0] RST_SRC_W = CFG_SW_W'(512);
    localparam logic [CFG_SW_W-1:0] RST_SRC_H = CFG_SW_W'(512);
    localparam logic [CFG_TW_W-1:0] RST_TGT_W = CFG_TW_W'(256);
    localparam logic [CFG_TW_W-1:0] RST_TGT_H = CFG_TW_W'(256);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_TGT_W = 2'd2,
        REG_TGT_H = 2'd3
    } t_reg;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } t_action;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] source_pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             last_pixel;
    } t_out_item;

    typedef struct packed {
        t_action          kind;
        logic [PIX_W-1:0] pixel;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_port;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_BOUND_GO,
        ST_BOUND_WAIT,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_DONE
    } t_state;

    // Widen an empty span to one pixel, then clip it at the source edge.
    function automatic logic [CFG_SW_W-1:0] box_fix_hi(
        input logic [CFG_SW_W-1:0] lo,
        input logic [CFG_SW_W-1:0] hi,
        input logic [CFG_SW_W-1:0] s
    );
        logic [CFG_SW_W-1:0] h;
        h = hi;
        if (h <= lo) begin
            h = lo + CFG_SW_W'(1);
        end
        if (h > s) begin
            h = s;
        end
        return h;
    endfunction

endpackage

// File: design/box_average_image_shrink.sv
// Area-averaging downscaler for ARGB8888 frames. Push load transactions
// (action 0) carrying source pixels in raster order, then fetch transactions
// (action 1); each fetch yields the next destination pixel in raster order,
// with last_pixel set on the final pixel of the frame. A load is written to
// the frame store as it is taken and leaves the engine free for the next
// command. A fetch makes one read of the frame store per box pixel on
// the single read port, plus two bit-serial divide passes (box bounds, then
// the per-channel averages). A four-entry command queue in front and a
// result register behind let the push and pop sides stall independently.
// Set the frame size through the register port only while no transaction is
// outstanding. The frame store has no reset; fetch only boxes already loaded.
module box_average_image_shrink
    import bbs_pkg::*;
#(
    parameter int MAX_SRC_W   = DEF_MAX_SRC_W,
    parameter int MAX_SRC_H   = DEF_MAX_SRC_H,
    parameter int MAX_DST_DIM = DEF_MAX_DST_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_SW_W-1:0] r_src_w, r_src_h;
    logic [CFG_TW_W-1:0] r_tgt_w, r_tgt_h;
    logic [CFG_SW_W-1:0] eff_sw, eff_sh;
    logic [CFG_TW_W-1:0] eff_dw, eff_dh;
    t_reg                reg_sel;
    logic                cfg_wr;
    t_cmd_port           cmd;
    logic                cmd_pop;
    logic                out_valid;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_W;
            r_src_h <= RST_SRC_H;
            r_tgt_w <= RST_TGT_W;
            r_tgt_h <= RST_TGT_H;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_SRC_W: r_src_w <= pwdata[CFG_SW_W-1:0];
                REG_SRC_H: r_src_h <= pwdata[CFG_SW_W-1:0];
                REG_TGT_W: r_tgt_w <= pwdata[CFG_TW_W-1:0];
                REG_TGT_H: r_tgt_h <= pwdata[CFG_TW_W-1:0];
                default:   ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_sel)
            REG_SRC_W: prdata = APB_DATA_W'(r_src_w);
            REG_SRC_H: prdata = APB_DATA_W'(r_src_h);
            REG_TGT_W: prdata = APB_DATA_W'(r_tgt_w);
            REG_TGT_H: prdata = APB_DATA_W'(r_tgt_h);
            default:   prdata = '0;
        endcase
    end

    // Effective dimensions: zero acts as one, oversize saturates
    assign eff_sw = (r_src_w == '0) ? CFG_SW_W'(1) :
                    (32'(r_src_w) > MAX_SRC_W) ? CFG_SW_W'(MAX_SRC_W) : r_src_w;
    assign eff_sh = (r_src_h == '0) ? CFG_SW_W'(1) :
                    (32'(r_src_h) > MAX_SRC_H) ? CFG_SW_W'(MAX_SRC_H) : r_src_h;
    assign eff_dw = (r_tgt_w == '0) ? CFG_TW_W'(1) :
                    (32'(r_tgt_w) > MAX_DST_DIM) ? CFG_TW_W'(MAX_DST_DIM) : r_tgt_w;
    assign eff_dh = (r_tgt_h == '0) ? CFG_TW_W'(1) :
                    (32'(r_tgt_h) > MAX_DST_DIM) ? CFG_TW_W'(MAX_DST_DIM) : r_tgt_h;

    bbs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    bbs_back #(
        .MAX_SRC_W   (MAX_SRC_W),
        .MAX_SRC_H   (MAX_SRC_H),
        .MAX_DST_DIM (MAX_DST_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sw        (eff_sw),
        .i_sh        (eff_sh),
        .i_dw        (eff_dw),
        .i_dh        (eff_dh),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (out_valid),
        .o_out_item  (o_out_item),
        .i_out_pop   (pop)
    );

    assign empty = !out_valid;

endmodule

// File: design/bbs_div.sv
module bbs_div
    import bbs_pkg::*;
#(
    parameter int NUM_W = 21,
    parameter int DEN_W = 11,
    parameter int QUO_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             fits;

    assign fits = (r_rem >= r_dsh);

    // Control: count down one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: restoring division, divisor shifted down one place a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NUM_W'(i_den) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// File: design/bbs_front.sv
module bbs_front
    import bbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output t_cmd_port o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd                  r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  do_push;
    logic                  do_pop;
    t_cmd                  cmd_in;

    assign full    = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = i_cmd_pop && (r_cnt != '0);

    // Classify the incoming transaction
    assign cmd_in.kind  = t_action'(i_in_item.action);
    assign cmd_in.pixel = i_in_item.source_pixel;

    // Hold classified commands until the back end takes them
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CMDQ_CNT_W'(1);
            end
        end
    end

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];

endmodule

// File: design/bbs_back.sv
module bbs_back
    import bbs_pkg::*;
#(
    parameter int MAX_SRC_W   = DEF_MAX_SRC_W,
    parameter int MAX_SRC_H   = DEF_MAX_SRC_H,
    parameter int MAX_DST_DIM = DEF_MAX_DST_DIM
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CFG_SW_W-1:0] i_sw,
    input  logic [CFG_SW_W-1:0] i_sh,
    input  logic [CFG_TW_W-1:0] i_dw,
    input  logic [CFG_TW_W-1:0] i_dh,
    input  t_cmd_port           i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    output t_out_item           o_out_item,
    input  logic                i_out_pop
);

    localparam int DEPTH    = MAX_SRC_W * MAX_SRC_H;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FRAME_W  = 2 * CFG_SW_W;
    localparam int LP_W     = (ADDR_W + 1 > FRAME_W) ? ADDR_W + 1 : FRAME_W;
    localparam int DST_LIM  = (MAX_DST_DIM < TGT_REG_MAX) ? MAX_DST_DIM : TGT_REG_MAX;
    localparam int POS_W    = (DST_LIM > 1) ? $clog2(DST_LIM) : 1;
    localparam int BNUM_W   = CFG_TW_W + CFG_SW_W;
    localparam int N_W      = 2 * CFG_SW_W;
    localparam int SUM_W    = N_W + CH_W;

    t_state r_state;
    t_state n_state;

    logic [PIX_W-1:0]  r_mem [DEPTH];
    logic [PIX_W-1:0]  r_rd_data;
    logic              r_rd_valid;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_issue;
    logic              mem_we;

    logic [FRAME_W-1:0] r_frame;
    logic [ADDR_W-1:0]  r_load_pos;
    logic [ADDR_W-1:0]  load_addr;
    logic [ADDR_W:0]    load_next;

    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_cur_col;
    logic [POS_W-1:0] r_cur_row;
    logic             pos_wrap;

    logic [BNUM_W-1:0]   r_nx0, r_nx1, r_ny0, r_ny1;
    logic [CFG_SW_W-1:0] qx0, qx1, qy0, qy1;
    logic [3:0]          bnd_busy;
    logic                bnd_start;

    logic [CFG_SW_W-1:0] r_x0, r_x1, r_y1, r_x, r_y;
    logic [ADDR_W-1:0]   r_base;

    logic [SUM_W-1:0] r_sum [NUM_CH];
    logic [N_W-1:0]   r_n;
    logic [CH_W-1:0]  avg_q [NUM_CH];
    logic [NUM_CH-1:0] avg_busy;
    logic              avg_start;

    logic             out_load;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             last;
    logic [CFG_TW_W-1:0] col_inc;
    logic [CFG_TW_W-1:0] row_inc;

    // Frame size for load wrap; configuration settles well before use
    always_ff @(posedge i_clk) begin
        r_frame <= FRAME_W'(i_sw) * FRAME_W'(i_sh);
    end

    assign load_addr = (LP_W'(r_load_pos) >= LP_W'(r_frame)) ? '0 : r_load_pos;
    assign load_next = (ADDR_W + 1)'(load_addr) + (ADDR_W + 1)'(1);
    assign pos_wrap  = (CFG_TW_W'(r_col) >= i_dw) || (CFG_TW_W'(r_row) >= i_dh);

    // Frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[load_addr] <= i_cmd.cmd.pixel;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Box bound dividers: floor(d*s/D) for both edges in both axes
    bbs_div #(.NUM_W(BNUM_W), .DEN_W(CFG_TW_W), .QUO_W(CFG_SW_W)) u_div_x0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(bnd_start),
        .i_num(r_nx0), .i_den(i_dw), .o_busy(bnd_busy[0]), .o_quo(qx0));
    bbs_div #(.NUM_W(BNUM_W), .DEN_W(CFG_TW_W), .QUO_W(CFG_SW_W)) u_div_x1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(bnd_start),
        .i_num(r_nx1), .i_den(i_dw), .o_busy(bnd_busy[1]), .o_quo(qx1));
    bbs_div #(.NUM_W(BNUM_W), .DEN_W(CFG_TW_W), .QUO_W(CFG_SW_W)) u_div_y0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(bnd_start),
        .i_num(r_ny0), .i_den(i_dh), .o_busy(bnd_busy[2]), .o_quo(qy0));
    bbs_div #(.NUM_W(BNUM_W), .DEN_W(CFG_TW_W), .QUO_W(CFG_SW_W)) u_div_y1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(bnd_start),
        .i_num(r_ny1), .i_den(i_dh), .o_busy(bnd_busy[3]), .o_quo(qy1));

    // Channel averaging: one divider lane per channel
    for (genvar c = 0; c < NUM_CH; c++) begin : g_avg
        bbs_div #(.NUM_W(SUM_W), .DEN_W(N_W), .QUO_W(CH_W)) u_div_ch (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(avg_start),
            .i_num(r_sum[c]), .i_den(r_n), .o_busy(avg_busy[c]), .o_quo(avg_q[c]));
    end

    // Sequencer: next state and strobes
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        rd_issue  = 1'b0;
        rd_addr   = r_base + ADDR_W'(r_x);
        bnd_start = 1'b0;
        avg_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.cmd.kind == ACT_LOAD) begin
                        mem_we = 1'b1;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL:      n_state = ST_BOUND_GO;
            ST_BOUND_GO: begin
                bnd_start = 1'b1;
                n_state   = ST_BOUND_WAIT;
            end
            ST_BOUND_WAIT: begin
                if (bnd_busy == '0) begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE:     n_state = ST_SCAN;
            ST_SCAN: begin
                rd_issue = 1'b1;
                if ((r_x + CFG_SW_W'(1) == r_x1) && (r_y + CFG_SW_W'(1) == r_y1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:    n_state = ST_AVG_GO;
            ST_AVG_GO: begin
                avg_start = 1'b1;
                n_state   = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (avg_busy == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_pop) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign last    = (CFG_TW_W'(r_cur_col) == i_dw - CFG_TW_W'(1)) &&
                     (CFG_TW_W'(r_cur_row) == i_dh - CFG_TW_W'(1));
    assign col_inc = CFG_TW_W'(r_cur_col) + CFG_TW_W'(1);
    assign row_inc = CFG_TW_W'(r_cur_row) + CFG_TW_W'(1);

    // Control registers: positions, read pipe, result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= rd_issue;
            if (mem_we) begin
                r_load_pos <= (LP_W'(load_next) >= LP_W'(r_frame)) ? '0
                                                                   : ADDR_W'(load_next);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (col_inc >= i_dw) begin
                    r_col <= '0;
                    r_row <= (row_inc >= i_dh) ? '0 : POS_W'(row_inc);
                end else begin
                    r_col <= POS_W'(col_inc);
                    r_row <= r_cur_row;
                end
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: bounds, scan counters, channel sums
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd.valid) begin
            r_cur_col <= pos_wrap ? '0 : r_col;
            r_cur_row <= pos_wrap ? '0 : r_row;
        end
        if (r_state == ST_MUL) begin
            r_nx0 <= BNUM_W'(r_cur_col) * BNUM_W'(i_sw);
            r_nx1 <= (BNUM_W'(r_cur_col) + BNUM_W'(1)) * BNUM_W'(i_sw);
            r_ny0 <= BNUM_W'(r_cur_row) * BNUM_W'(i_sh);
            r_ny1 <= (BNUM_W'(r_cur_row) + BNUM_W'(1)) * BNUM_W'(i_sh);
        end
        if (r_state == ST_BOUND_WAIT && bnd_busy == '0) begin
            r_x0 <= qx0;
            r_x1 <= box_fix_hi(qx0, qx1, i_sw);
            r_y  <= qy0;
            r_y1 <= box_fix_hi(qy0, qy1, i_sh);
        end
        if (r_state == ST_BASE) begin
            r_base <= ADDR_W'(FRAME_W'(r_y) * FRAME_W'(i_sw));
            r_x    <= r_x0;
            r_n    <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
            end
        end
        if (rd_issue) begin
            if (r_x + CFG_SW_W'(1) == r_x1) begin
                r_x    <= r_x0;
                r_y    <= r_y + CFG_SW_W'(1);
                r_base <= r_base + ADDR_W'(i_sw);
            end else begin
                r_x <= r_x + CFG_SW_W'(1);
            end
        end
        if (r_rd_valid) begin
            r_n <= r_n + N_W'(1);
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(r_rd_data[c*CH_W +: CH_W]);
            end
        end
        if (out_load) begin
            r_out_item.result_pixel <= {avg_q[3], avg_q[2], avg_q[1], avg_q[0]};
            r_out_item.last_pixel   <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
